>>> hw/rtl/pfsb_pkg.sv
// Shared types and codes for the page framebuffer sprite blitter.
package pfsb_pkg;

	// Command codes on the request channel
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_MERGE = 2'd1;
	localparam logic [1:0] CMD_COPY  = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_MERGE,
		OP_COPY,
		OP_READ
	} op_kind_t;

	// Classified operation handed from the front to the back.
	// flag: merge has a spill into the next page / read address is in range.
	typedef struct packed {
		op_kind_t    kind;
		logic        flag;
		logic [7:0]  lo;
		logic [7:0]  hi;
	} op_ctl_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_MERGE_LO,
		BK_MERGE_HI,
		BK_READ
	} back_state_t;

endpackage

>>> hw/rtl/pfsb_req_if.sv
// Request channel: one command transaction per handshake.
interface pfsb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] base_x;
	logic [7:0] pos_y;
	logic [6:0] column_offset;
	logic [7:0] pixel_byte;
	logic [9:0] read_address;

	modport source (
		output valid, cmd, base_x, pos_y, column_offset, pixel_byte, read_address,
		input  ready
	);
	modport sink (
		input  valid, cmd, base_x, pos_y, column_offset, pixel_byte, read_address,
		output ready
	);
endinterface

>>> hw/rtl/pfsb_rsp_if.sv
// Response channel: read data transactions.
interface pfsb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (
		output valid, read_data,
		input  ready
	);
	modport sink (
		input  valid, read_data,
		output ready
	);
endinterface

>>> hw/rtl/page_framebuffer_sprite_blitter_top.sv
// Top level of the page framebuffer sprite blitter.
//
//   port  dir   handshake      carries
//   req   in    valid/ready    cmd, base_x, pos_y, column_offset, pixel_byte, read_address
//   rsp   out   valid/ready    read_data (read command only)
//
// Commands pass a registered front stage and a two-entry queue into the store engine.
// In the engine a copy writes its byte; a merge reads the stored byte and writes it back
// ORed, also in the next page when it spills; a read loads the response register;
// a clear zeroes the store. After reset the engine sweeps all COLUMNS*PAGES bytes
// (1024 by default) to zero and holds req.ready low until the sweep ends.
// A read waits in the queue while the response register holds an untaken result.
module page_framebuffer_sprite_blitter_top #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	pfsb_req_if.sink   req,
	pfsb_rsp_if.source rsp
);

	localparam int ADDR_W  = $clog2(COLUMNS * PAGES);
	localparam int OP_W    = $bits(pfsb_pkg::op_ctl_t) + ADDR_W;
	localparam int Q_DEPTH = 2;

	logic                  push_valid;
	logic                  push_ready;
	pfsb_pkg::op_ctl_t     push_ctl;
	logic [ADDR_W-1:0]     push_addr;
	logic                  head_valid;
	logic                  head_pop;
	logic [OP_W-1:0]       head_data;
	pfsb_pkg::op_ctl_t     head_ctl;
	logic [ADDR_W-1:0]     head_addr;
	logic                  init_busy;

	pfsb_front #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES),
		.ADDR_W  (ADDR_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (init_busy),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctl   (push_ctl),
		.push_addr  (push_addr)
	);

	pfsb_queue #(
		.W     (OP_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_ctl, push_addr}),
		.pop_valid  (head_valid),
		.pop        (head_pop),
		.pop_data   (head_data)
	);

	assign head_ctl  = head_data[OP_W-1:ADDR_W];
	assign head_addr = head_data[ADDR_W-1:0];

	pfsb_back #(
		.COLUMNS (COLUMNS),
		.PAGES   (PAGES),
		.ADDR_W  (ADDR_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_ctl   (head_ctl),
		.head_addr  (head_addr),
		.pop        (head_pop),
		.init_busy  (init_busy),
		.rsp        (rsp)
	);

endmodule

>>> hw/rtl/pfsb_front.sv
// Front end: accepts commands, range-checks them and forms store operations.
module pfsb_front #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8,
	parameter int ADDR_W  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hold,
	pfsb_req_if.sink              req,
	output logic                  push_valid,
	input  logic                  push_ready,
	output pfsb_pkg::op_ctl_t     push_ctl,
	output logic [ADDR_W-1:0]     push_addr
);

	localparam int STORE_DEPTH = COLUMNS * PAGES;
	localparam int CMP_W       = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;

	logic                  v_s1;
	pfsb_pkg::op_ctl_t     ctl_s1;
	logic [ADDR_W-1:0]     addr_s1;

	logic                  accept;
	logic                  keep;
	pfsb_pkg::op_ctl_t     ctl_d;
	logic [ADDR_W-1:0]     addr_d;

	logic [8:0]            col;
	logic                  blit_ok;
	logic [4:0]            page;
	logic [2:0]            shift;
	logic [15:0]           shifted;
	logic                  has_hi;
	logic [ADDR_W-1:0]     blit_addr;
	logic                  rd_in_range;

	assign col     = {1'b0, req.base_x} + {2'b00, req.column_offset};
	assign blit_ok = ({1'b0, req.base_x} < 9'(COLUMNS)) &&
	                 (col < 9'(COLUMNS)) &&
	                 ({1'b0, req.pos_y} < 9'(PAGES * 8));
	assign page    = req.pos_y[7:3];
	assign shift   = req.pos_y[2:0];
	assign shifted = {8'h00, req.pixel_byte} << shift;
	// Spill only when the shift moves bits out and a page lies below
	assign has_hi  = (shift != 3'd0) && ((6'(page) + 6'd1) < 6'(PAGES));
	assign blit_addr   = ADDR_W'(int'(page) * COLUMNS + int'(col));
	assign rd_in_range = CMP_W'(req.read_address) < CMP_W'(STORE_DEPTH);

	always_comb begin
		keep   = 1'b1;
		ctl_d  = '0;
		addr_d = blit_addr;
		case (req.cmd)
			pfsb_pkg::CMD_CLEAR: begin
				ctl_d.kind = pfsb_pkg::OP_CLEAR;
			end
			pfsb_pkg::CMD_MERGE: begin
				keep       = blit_ok;
				ctl_d.kind = pfsb_pkg::OP_MERGE;
				ctl_d.flag = has_hi;
				ctl_d.lo   = shifted[7:0];
				ctl_d.hi   = shifted[15:8];
			end
			pfsb_pkg::CMD_COPY: begin
				keep       = blit_ok;
				ctl_d.kind = pfsb_pkg::OP_COPY;
				ctl_d.lo   = req.pixel_byte;
			end
			pfsb_pkg::CMD_READ: begin
				ctl_d.kind = pfsb_pkg::OP_READ;
				ctl_d.flag = rd_in_range;
				addr_d     = ADDR_W'(req.read_address);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign req.ready = !hold && (!v_s1 || push_ready);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			// drop blits that fall off the store
			v_s1 <= keep;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_d;
			addr_s1 <= addr_d;
		end
	end

	assign push_valid = v_s1;
	assign push_ctl   = ctl_s1;
	assign push_addr  = addr_s1;

endmodule

>>> hw/rtl/pfsb_queue.sv
// Small FIFO between the front end and the store engine.
module pfsb_queue #(
	parameter int W     = 29,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hw/rtl/pfsb_back.sv
// Store engine: frame memory, clear sweep, read-modify-write and read response.
module pfsb_back #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8,
	parameter int ADDR_W  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  pfsb_pkg::op_ctl_t     head_ctl,
	input  logic [ADDR_W-1:0]     head_addr,
	output logic                  pop,
	output logic                  init_busy,
	pfsb_rsp_if.source            rsp
);

	localparam int STORE_DEPTH            = COLUMNS * PAGES;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);

	logic [7:0] mem [STORE_DEPTH];

	pfsb_pkg::back_state_t state_q;
	pfsb_pkg::back_state_t state_d;

	logic [ADDR_W-1:0] clr_addr_q;
	logic              init_q;
	logic              op_flag_q;
	logic [7:0]        op_lo_q;
	logic [7:0]        op_hi_q;
	logic [ADDR_W-1:0] op_addr_q;
	logic [7:0]        rdata_q;
	logic              out_valid_q;
	logic [7:0]        out_data_q;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic              load_op;
	logic              out_load;
	logic              out_free;
	logic              clr_last;

	// output slot is empty by the next cycle
	assign out_free = !out_valid_q || rsp.ready;
	assign clr_last = clr_addr_q == LAST_ADDR;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfsb_pkg::BK_IDLE: begin
				if (head_valid) begin
					case (head_ctl.kind)
						pfsb_pkg::OP_CLEAR: state_d = pfsb_pkg::BK_CLEAR;
						pfsb_pkg::OP_MERGE: state_d = pfsb_pkg::BK_MERGE_LO;
						pfsb_pkg::OP_READ:  state_d = out_free ? pfsb_pkg::BK_READ
						                                       : pfsb_pkg::BK_IDLE;
						default:            state_d = pfsb_pkg::BK_IDLE;
					endcase
				end
			end
			pfsb_pkg::BK_CLEAR:    state_d = clr_last ? pfsb_pkg::BK_IDLE : pfsb_pkg::BK_CLEAR;
			pfsb_pkg::BK_MERGE_LO: state_d = op_flag_q ? pfsb_pkg::BK_MERGE_HI
			                                           : pfsb_pkg::BK_IDLE;
			pfsb_pkg::BK_MERGE_HI: state_d = pfsb_pkg::BK_IDLE;
			pfsb_pkg::BK_READ:     state_d = pfsb_pkg::BK_IDLE;
			default:               state_d = pfsb_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		we       = 1'b0;
		waddr    = head_addr;
		wdata    = head_ctl.lo;
		re       = 1'b0;
		raddr    = head_addr;
		load_op  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			pfsb_pkg::BK_IDLE: begin
				if (head_valid) begin
					case (head_ctl.kind)
						pfsb_pkg::OP_CLEAR: begin
							pop = 1'b1;
						end
						pfsb_pkg::OP_COPY: begin
							pop = 1'b1;
							we  = 1'b1;
						end
						pfsb_pkg::OP_MERGE: begin
							pop     = 1'b1;
							re      = 1'b1;
							load_op = 1'b1;
						end
						pfsb_pkg::OP_READ: begin
							// hold the read until its result has a place to go
							pop     = out_free;
							re      = out_free && head_ctl.flag;
							load_op = out_free;
						end
						default: begin
							pop = 1'b0;
						end
					endcase
				end
			end
			pfsb_pkg::BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = 8'h00;
			end
			pfsb_pkg::BK_MERGE_LO: begin
				we    = 1'b1;
				waddr = op_addr_q;
				wdata = rdata_q | op_lo_q;
				re    = op_flag_q;
				raddr = op_addr_q + COL_STEP;
			end
			pfsb_pkg::BK_MERGE_HI: begin
				we    = 1'b1;
				waddr = op_addr_q + COL_STEP;
				wdata = rdata_q | op_hi_q;
			end
			pfsb_pkg::BK_READ: begin
				out_load = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfsb_pkg::BK_CLEAR;
			clr_addr_q  <= '0;
			init_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfsb_pkg::BK_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
				if (clr_last) begin
					init_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_op) begin
			op_flag_q <= head_ctl.flag;
			op_lo_q   <= head_ctl.lo;
			op_hi_q   <= head_ctl.hi;
			op_addr_q <= head_addr;
		end
		if (out_load) begin
			out_data_q <= op_flag_q ? rdata_q : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign init_busy     = init_q;
	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the page framebuffer sprite blitter: random and directed commands.
module testbench;

	localparam int COLUMNS      = 128;
	localparam int PAGES        = 8;
	localparam int STORE_BYTES  = COLUMNS * PAGES;
	localparam int ROW_MAX      = PAGES * 8 - 1;
	localparam int ITEM_TARGET  = 850;
	localparam int STALL_MAX    = 14;
	localparam int IDLE_LIMIT   = 8000;
	localparam int DRAIN_CYCLES = 3200;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] base_x;
		logic [7:0] pos_y;
		logic [6:0] column_offset;
		logic [7:0] pixel_byte;
		logic [9:0] read_address;
	} blit_cmd_t;

	// Shadow copy of the frame store; predicts every read and checks it in order.
	class frame_shadow;
		logic [7:0] store [STORE_BYTES];
		logic [7:0] pending_reads [$];
		int failures;
		int clears;
		int merges;
		int copies;
		int dropped;
		int reads_checked;

		function new();
			wipe();
		endfunction

		function void wipe();
			foreach (store[i])
				store[i] = 8'h00;
		endfunction

		function void apply_command(blit_cmd_t c);
			int col;
			int addr;
			logic [15:0] shifted;
			case (c.cmd)
			pfsb_pkg::CMD_CLEAR: begin
				clears++;
				wipe();
			end
			pfsb_pkg::CMD_MERGE, pfsb_pkg::CMD_COPY: begin
				col = int'(c.base_x) + int'(c.column_offset);
				// drop blits off the frame; columns past the right edge do not wrap
				if (c.base_x > COLUMNS - 1 || c.pos_y > ROW_MAX || col >= COLUMNS) begin
					dropped++;
				end else begin
					addr = int'(c.pos_y[7:3]) * COLUMNS + col;
					if (c.cmd == pfsb_pkg::CMD_COPY) begin
						copies++;
						store[addr] = c.pixel_byte;
					end else begin
						merges++;
						shifted = {8'h00, c.pixel_byte} << c.pos_y[2:0];
						store[addr] |= shifted[7:0];
						// no spill below the last page
						if (addr + COLUMNS < STORE_BYTES)
							store[addr + COLUMNS] |= shifted[15:8];
					end
				end
			end
			default: begin
				pending_reads.push_back((int'(c.read_address) < STORE_BYTES) ?
					store[c.read_address] : 8'h00);
			end
			endcase
		endfunction

		function void check_read_data(logic [7:0] data);
			logic [7:0] want;
			if (pending_reads.size() == 0) begin
				failures++;
				$display("%0t: read_data unexpected, expected none actual %02h", $time, data);
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (data !== want) begin
					failures++;
					$display("%0t: read_data mismatch, expected %02h actual %02h",
						$time, want, data);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   send_calm;
	bit   recv_calm;

	pfsb_req_if req_ch();
	pfsb_rsp_if rsp_ch();

	frame_shadow shadow = new();

	page_framebuffer_sprite_blitter_top #(
		.COLUMNS(COLUMNS),
		.PAGES  (PAGES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic blit_cmd_t pack_cmd(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
		logic [6:0] off, logic [7:0] pix, logic [9:0] addr);
		blit_cmd_t c;
		c.cmd           = cmd;
		c.base_x        = x;
		c.pos_y         = y;
		c.column_offset = off;
		c.pixel_byte    = pix;
		c.read_address  = addr;
		return c;
	endfunction

	// Present one command after a random gap and hold it until the handshake.
	task automatic send_command(blit_cmd_t c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= c.cmd;
		req_ch.base_x        <= c.base_x;
		req_ch.pos_y         <= c.pos_y;
		req_ch.column_offset <= c.column_offset;
		req_ch.pixel_byte    <= c.pixel_byte;
		req_ch.read_address  <= c.read_address;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
	endtask

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			shadow.apply_command(pack_cmd(req_ch.cmd, req_ch.base_x, req_ch.pos_y,
				req_ch.column_offset, req_ch.pixel_byte, req_ch.read_address));
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			shadow.check_read_data(rsp_ch.read_data);
	end

	initial begin : rsp_sink
		int stall;
		recv_calm = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, STALL_MAX);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
		end
	end

	// End the run when no transaction moves for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		blit_cmd_t c;
		int effective;
		int roll;
		int last_touch;
		int addr;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= pfsb_pkg::CMD_CLEAR;
		req_ch.base_x        <= 8'h00;
		req_ch.pos_y         <= 8'h00;
		req_ch.column_offset <= 7'h00;
		req_ch.pixel_byte    <= 8'h00;
		req_ch.read_address  <= 10'h000;
		send_calm  = 1'b0;
		last_touch = 0;
		effective  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// store starts out zero at both ends
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd255, 8'd255, 7'd127, 8'hFF, 10'd1023));
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd0, 8'd0, 7'd0, 8'hFF, 10'd0));
		// last page, spill discarded
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd127, 8'd63, 7'd0, 8'hFF, 10'd0));
		// shifted merge with a spill into the page below
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd10, 8'd13, 7'd5, 8'hA5, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd10, 8'd13, 7'd5, 8'h00, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_COPY, 8'd0, 8'd7, 7'd127, 8'h81, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_COPY, 8'd127, 8'd56, 7'd0, 8'h3C, 10'd0));
		// off-frame blits: base column, row and right edge
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd128, 8'd0, 7'd0, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_COPY, 8'd255, 8'd0, 7'd0, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd0, 8'd64, 7'd0, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_COPY, 8'd5, 8'd255, 7'd0, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_MERGE, 8'd100, 8'd9, 7'd28, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_COPY, 8'd127, 8'd0, 7'd127, 8'hFF, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd128));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd143));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd271));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd127));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd1023));
		send_command(pack_cmd(pfsb_pkg::CMD_CLEAR, 8'd0, 8'd0, 7'd0, 8'h00, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd0));
		send_command(pack_cmd(pfsb_pkg::CMD_READ, 8'd0, 8'd0, 7'd0, 8'h00, 10'd1023));

		while (effective < ITEM_TARGET) begin
			roll = $urandom_range(0, 199);
			c = pack_cmd(pfsb_pkg::CMD_READ, 8'($urandom), 8'($urandom), 7'($urandom),
				8'($urandom), 10'($urandom));
			if (roll < 3) begin
				c.cmd = pfsb_pkg::CMD_CLEAR;
				effective++;
			end else if (roll < 130) begin
				c.cmd = (roll < 80) ? pfsb_pkg::CMD_MERGE : pfsb_pkg::CMD_COPY;
				// mostly on-frame columns; the rest stays as raw noise
				if ($urandom_range(0, 9) != 0) begin
					c.base_x        = 8'($urandom_range(0, COLUMNS - 1));
					c.pos_y         = 8'($urandom_range(0, ROW_MAX));
					c.column_offset = 7'($urandom_range(0, COLUMNS - 1 - int'(c.base_x)));
					last_touch = int'(c.pos_y[7:3]) * COLUMNS + int'(c.base_x) +
						int'(c.column_offset);
					effective++;
				end
			end else begin
				// aim half the reads at the column just drawn or the page below it
				if ($urandom_range(0, 1) == 0) begin
					addr = last_touch + ($urandom_range(0, 1) ? COLUMNS : 0);
					if (addr >= STORE_BYTES)
						addr -= COLUMNS;
					c.read_address = 10'(addr);
				end
				effective++;
			end
			send_command(c);
		end
		req_ch.valid <= 1'b0;

		while (shadow.pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d clears, %0d merges, %0d copies and %0d checked reads;",
			shadow.clears, shadow.merges, shadow.copies, shadow.reads_checked);
		$display("%0d blits fell outside the frame and were dropped.", shadow.dropped);
		if (shadow.failures == 0 && shadow.pending_reads.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
